[sv/tkd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tkd_pkg;

    // Configuration port geometry: two 8-bit registers at byte addresses 0 and 4.
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_IDX_ROWS = 1'b0;
    localparam logic REG_IDX_COLS = 1'b1;

    // Register reset values.
    localparam logic [7:0] ROWS_RESET = 8'd24;
    localparam logic [7:0] COLS_RESET = 8'd80;

    // Default depth of the key queue between the parser and the cursor unit.
    localparam int QUEUE_DEPTH = 4;

    // Byte values seen on the terminal link.
    localparam logic [7:0] CHR_ESC      = 8'h1b;
    localparam logic [7:0] CHR_LBRACKET = 8'h5b;
    localparam logic [7:0] CHR_O        = 8'h4f;
    localparam logic [7:0] CHR_TILDE    = 8'h7e;
    localparam logic [7:0] CHR_A        = 8'h41;
    localparam logic [7:0] CHR_B        = 8'h42;
    localparam logic [7:0] CHR_C        = 8'h43;
    localparam logic [7:0] CHR_D        = 8'h44;
    localparam logic [7:0] CHR_F        = 8'h46;
    localparam logic [7:0] CHR_H        = 8'h48;
    localparam logic [7:0] CHR_0        = 8'h30;
    localparam logic [7:0] CHR_1        = 8'h31;
    localparam logic [7:0] CHR_3        = 8'h33;
    localparam logic [7:0] CHR_4        = 8'h34;
    localparam logic [7:0] CHR_5        = 8'h35;
    localparam logic [7:0] CHR_6        = 8'h36;
    localparam logic [7:0] CHR_7        = 8'h37;
    localparam logic [7:0] CHR_8        = 8'h38;
    localparam logic [7:0] CHR_9        = 8'h39;
    localparam logic [7:0] CTRL_MASK    = 8'h1f;
    localparam logic [7:0] CHR_CTRL_Q   = 8'h71 & CTRL_MASK;

    // Key codes carried in a word.
    localparam int KEY_W = 9;
    localparam logic [KEY_W-1:0] KEY_ESC    = {1'b0, CHR_ESC};
    localparam logic [KEY_W-1:0] KEY_CTRL_Q = {1'b0, CHR_CTRL_Q};
    localparam logic [KEY_W-1:0] KEY_LEFT   = 9'd256;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 9'd257;
    localparam logic [KEY_W-1:0] KEY_UP     = 9'd258;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 9'd259;
    localparam logic [KEY_W-1:0] KEY_DEL    = 9'd260;
    localparam logic [KEY_W-1:0] KEY_HOME   = 9'd261;
    localparam logic [KEY_W-1:0] KEY_END    = 9'd262;
    localparam logic [KEY_W-1:0] KEY_PGUP   = 9'd263;
    localparam logic [KEY_W-1:0] KEY_PGDN   = 9'd264;

    // Escape sequence parser phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_BRACKET,
        PH_OHH,
        PH_OTHER,
        PH_DIGIT
    } phase_t;

    // Screen geometry handed to the cursor unit.
    typedef struct packed {
        logic [7:0] rows;
        logic [7:0] cols;
    } screen_t;

    // Status of the key queue as seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Key for the final letter of ESC [ letter or ESC O letter.
    function automatic logic [KEY_W-1:0] letter_key(input logic [7:0] b, input logic arrows);
        logic [KEY_W-1:0] k;
        k = KEY_ESC;
        if (arrows && b == CHR_A) k = KEY_UP;
        else if (arrows && b == CHR_B) k = KEY_DOWN;
        else if (arrows && b == CHR_C) k = KEY_RIGHT;
        else if (arrows && b == CHR_D) k = KEY_LEFT;
        else if (b == CHR_H) k = KEY_HOME;
        else if (b == CHR_F) k = KEY_END;
        return k;
    endfunction

    // Key for the digit of ESC [ digit ~.
    function automatic logic [KEY_W-1:0] digit_key(input logic [7:0] d);
        logic [KEY_W-1:0] k;
        case (d)
            CHR_1, CHR_7: k = KEY_HOME;
            CHR_3:        k = KEY_DEL;
            CHR_4, CHR_8: k = KEY_END;
            CHR_5:        k = KEY_PGUP;
            CHR_6:        k = KEY_PGDN;
            default:      k = KEY_ESC;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[sv/tkd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tkd_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic                      command,
    input  wire logic [7:0]                in_byte,
    output logic                           emit,
    output logic [tkd_pkg::KEY_W-1:0]      key
);
    import tkd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       is_digit;

    assign is_digit = in_byte inside {[CHR_0:CHR_9]};

    // Next phase and held byte.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (!command && in_byte == CHR_ESC)
                    phase_next = PH_ESC;
            end
            else if (command)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                case (phase_reg)
                    PH_ESC:
                    begin
                        held_next = in_byte;
                        if (in_byte == CHR_LBRACKET)
                            phase_next = PH_BRACKET;
                        else if (in_byte == CHR_O)
                            phase_next = PH_OHH;
                        else
                            phase_next = PH_OTHER;
                    end
                    PH_BRACKET:
                    begin
                        if (is_digit)
                        begin
                            held_next  = in_byte;
                            phase_next = PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                        phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Key word produced by the accepted byte, if any.
    always_comb
    begin
        emit = 1'b0;
        key  = KEY_ESC;
        if (accept)
        begin
            if (phase_reg == PH_IDLE)
            begin
                emit = !command && in_byte != CHR_ESC;
                key  = {1'b0, in_byte};
            end
            else if (command)
            begin
                emit = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_ESC:
                        emit = 1'b0;
                    PH_BRACKET:
                    begin
                        emit = !is_digit;
                        key  = letter_key(in_byte, 1'b1);
                    end
                    PH_OHH:
                    begin
                        emit = 1'b1;
                        key  = letter_key(in_byte, 1'b0);
                    end
                    PH_DIGIT:
                    begin
                        emit = 1'b1;
                        key  = (in_byte == CHR_TILDE) ? digit_key(held_reg) : KEY_ESC;
                    end
                    default:
                        emit = 1'b1;
                endcase
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

[sv/tkd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tkd_queue #(
    parameter int DEPTH = tkd_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [tkd_pkg::KEY_W-1:0]     wr_key,
    input  wire logic                          rd_en,
    output logic [tkd_pkg::KEY_W-1:0]          rd_key,
    output tkd_pkg::queue_status_t             status
);
    import tkd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [KEY_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_key       = slot_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Key storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_key;
    end

endmodule

`default_nettype wire

[sv/tkd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tkd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tkd_pkg::screen_t              screen,
    input  wire tkd_pkg::queue_status_t        q_status,
    input  wire logic [tkd_pkg::KEY_W-1:0]     q_key,
    output logic                               q_pop,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [tkd_pkg::KEY_W-1:0]          key_code,
    output logic [7:0]                         cursor_col,
    output logic [7:0]                         cursor_row,
    output logic                               quit
);
    import tkd_pkg::*;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [KEY_W-1:0] key_reg;
    logic             quit_reg;
    logic [7:0]       col_reg;
    logic [7:0]       col_next;
    logic [7:0]       row_reg;
    logic [7:0]       row_next;
    logic [7:0]       rows_eff;
    logic [7:0]       last_row;
    logic [7:0]       last_col;
    logic             load;

    // A zero screen size counts as one.
    assign rows_eff = (screen.rows == '0) ? 8'd1 : screen.rows;
    assign last_row = rows_eff - 8'd1;
    assign last_col = ((screen.cols == '0) ? 8'd1 : screen.cols) - 8'd1;

    // Take the next key when the output word is free or leaving.
    assign load  = !q_status.empty && (!out_valid_reg || pop);
    assign q_pop = load;

    assign out_valid_next = load || (out_valid_reg && !pop);

    // Cursor move for the key at the head of the queue.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        case (q_key)
            KEY_LEFT:  if (col_reg != '0) col_next = col_reg - 8'd1;
            KEY_RIGHT: if (col_reg < last_col) col_next = col_reg + 8'd1;
            KEY_UP:    if (row_reg != '0) row_next = row_reg - 8'd1;
            KEY_DOWN:  if (row_reg < last_row) row_next = row_reg + 8'd1;
            KEY_HOME:  col_next = '0;
            KEY_END:   col_next = last_col;
            KEY_PGUP:  row_next = (row_reg > rows_eff) ? row_reg - rows_eff : '0;
            KEY_PGDN:  if (row_reg < last_row) row_next = last_row;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg  <= q_key;
            quit_reg <= (q_key == KEY_CTRL_Q);
        end
    end

    assign empty      = !out_valid_reg;
    assign key_code   = key_reg;
    assign cursor_col = col_reg;
    assign cursor_row = row_reg;
    assign quit       = quit_reg;

endmodule

`default_nettype wire

[sv/terminal_key_decoder_cursor.sv]
`timescale 1ns / 1ps
`default_nettype none

// Terminal key decoder with cursor tracking. Each accepted word is a received byte
// (command 0) or a read timeout (command 1); ESC [ letter, ESC [ digit ~ and ESC O
// letter become arrow, home, end, delete and page keys, other bytes pass through as
// plain keys, and a timeout or unknown sequence gives ESC. Every finished key yields
// one result word with the cursor position after the key, clamped to screen_rows by
// screen_cols (registers at byte addresses 0 and 4; zero counts as one). The block
// takes one input word per clock while full is low; the parser phase register tracks
// each byte, a key queue of QUEUE_DEPTH words decouples it from the cursor unit, and
// the cursor unit, whenever the result word is free or popped, loads the next key into
// its result registers and updates its row and column registers once per cycle.
// Configuration may only be written while no keys are in flight.
module terminal_key_decoder_cursor #(
    parameter int QUEUE_DEPTH = tkd_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input side.
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          command,
    input  wire logic [7:0]                    in_byte,
    // Result side.
    input  wire logic                          pop,
    output logic                               empty,
    output logic [tkd_pkg::KEY_W-1:0]          key_code,
    output logic [7:0]                         cursor_col,
    output logic [7:0]                         cursor_row,
    output logic                               quit,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tkd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [tkd_pkg::DATA_W-1:0]    pwdata,
    output logic [tkd_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import tkd_pkg::*;

    logic             rows_sel;
    logic [7:0]       screen_rows_reg;
    logic [7:0]       screen_cols_reg;
    logic             cfg_wr;
    logic             in_accept;
    logic             f_emit;
    logic [KEY_W-1:0] f_key;
    logic [KEY_W-1:0] q_key;
    logic             q_pop;
    queue_status_t    q_status;
    screen_t          screen;

    // Configuration registers.
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign rows_sel = (paddr[REG_SEL_BIT] == REG_IDX_ROWS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_rows_reg <= ROWS_RESET;
            screen_cols_reg <= COLS_RESET;
        end
        else if (cfg_wr)
        begin
            if (rows_sel)
                screen_rows_reg <= pwdata[7:0];
            else
                screen_cols_reg <= pwdata[7:0];
        end
    end

    assign prdata      = {{(DATA_W - 8){1'b0}}, rows_sel ? screen_rows_reg : screen_cols_reg};
    assign screen.rows = screen_rows_reg;
    assign screen.cols = screen_cols_reg;

    // Input handshake.
    assign full      = q_status.full;
    assign in_accept = push && !q_status.full;

    tkd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .command (command),
        .in_byte (in_byte),
        .emit    (f_emit),
        .key     (f_key)
    );

    tkd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (f_emit),
        .wr_key (f_key),
        .rd_en  (q_pop),
        .rd_key (q_key),
        .status (q_status)
    );

    tkd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .screen     (screen),
        .q_status   (q_status),
        .q_key      (q_key),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .key_code   (key_code),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .quit       (quit)
    );

    // The parser only produces a key for a word that the queue had room for.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        f_emit |-> !q_status.full)
        else $error("key queue written while full");

    // The cursor unit only takes keys that are present.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("key queue read while empty");

    // A key written without a read leaves the queue occupied.
    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (f_emit && !q_pop) |=> !q_status.empty)
        else $error("key lost in queue");

endmodule

`default_nettype wire
